### hw/rtl/sfe_pkg.sv
// shared constants and result types for the ssid / ip field extractor
// no dependencies; used by the capture units and the top level
package sfe_pkg;

    // default capture capacities
    localparam int SSID_CAP_DEF    = 10;
    localparam int IP_GROUP_CAP_DEF = 10;

    // reported position width
    localparam int POS_W = 4;

    // character codes
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_NUL   = 8'h00;

    // output request width: 25 payload bits padded to whole bytes
    localparam int OUT_BITS = 25;
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

    // ssid capture result for one byte
    typedef struct packed {
        logic             write;
        logic [POS_W-1:0] pos;
    } t_ssid_res;

    // ip capture result for one byte
    typedef struct packed {
        logic             first_write;
        logic [POS_W-1:0] first_pos;
        logic             second_write;
        logic [POS_W-1:0] second_pos;
        logic             overflow;
    } t_ip_res;

endpackage

### hw/rtl/ssid_ip_field_extractor_core.sv
// top level of the ssid / ip field extractor: input register, byte history,
// capture units and result register; depends on sfe_pkg, sfe_ssid_capture, sfe_ip_capture
//
// usage
// - slave channel: one received modem byte per request in i_s_tdata; a null
//   byte yields a result request with every field zero and changes no state
// - master channel: one result request per input request, in order
// - each request passes from the input register to the result register;
//   throughput one request per cycle while the receiver does not stall, set
//   by the state update of the two capture units
// - reset (i_rst_n low, synchronous) empties both registers and clears the
//   byte history and all capture state; each capture then runs afresh
// - when the receiver stalls, the result register holds and the input
//   register keeps its request; o_s_tready falls only while both are full,
//   so the input side keeps flowing as long as one slot is free
// - o_m_tdata fields from bit 0 up: echo_valid, echo_byte[7:0], ssid_write,
//   ssid_pos[3:0], ip_first_write, ip_first_pos[3:0], ip_second_write,
//   ip_second_pos[3:0], capture_overflow, zero padding
// - positions are reported in four bits
module ssid_ip_field_extractor_core #(
    parameter int SSID_CAPACITY     = sfe_pkg::SSID_CAP_DEF,
    parameter int IP_GROUP_CAPACITY = sfe_pkg::IP_GROUP_CAP_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_s_tvalid,
    output logic                     o_s_tready,
    input  logic [7:0]               i_s_tdata,   // rx_byte[7:0]
    output logic                     o_m_tvalid,
    input  logic                     i_m_tready,
    output logic [sfe_pkg::OUT_W-1:0] o_m_tdata   // see field list above
);

    logic                       r_in_valid;
    logic [7:0]                 r_in_byte;
    logic [7:0]                 r_last_byte;
    logic [7:0]                 r_prev_byte;
    logic                       r_out_valid;
    logic [sfe_pkg::OUT_W-1:0]  r_out_data;
    logic [sfe_pkg::OUT_W-1:0]  n_out_data;
    logic                       adv;
    logic                       nonzero;
    sfe_pkg::t_ssid_res         ssid_res;
    sfe_pkg::t_ip_res           ip_res;

    // pipeline flow control
    assign adv        = !r_out_valid || i_m_tready;
    assign o_s_tready = !r_in_valid || adv;
    assign nonzero    = r_in_valid && (r_in_byte != sfe_pkg::CH_NUL);

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_byte <= i_s_tdata;
        end
    end

    // two-byte history of nonzero bytes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_byte <= '0;
            r_prev_byte <= '0;
        end else if (adv && nonzero) begin
            r_prev_byte <= r_last_byte;
            r_last_byte <= r_in_byte;
        end
    end

    sfe_ssid_capture #(
        .SSID_CAPACITY (SSID_CAPACITY)
    ) u_ssid (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (nonzero),
        .i_adv       (adv),
        .i_byte      (r_in_byte),
        .i_last_byte (r_last_byte),
        .o_res       (ssid_res)
    );

    sfe_ip_capture #(
        .IP_GROUP_CAPACITY (IP_GROUP_CAPACITY)
    ) u_ip (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (nonzero),
        .i_adv       (adv),
        .i_byte      (r_in_byte),
        .i_last_byte (r_last_byte),
        .i_prev_byte (r_prev_byte),
        .o_res       (ip_res)
    );

    // pack the result request
    always_comb begin
        n_out_data        = '0;
        n_out_data[0]     = nonzero;
        n_out_data[8:1]   = nonzero ? r_in_byte : 8'h00;
        n_out_data[9]     = ssid_res.write;
        n_out_data[13:10] = ssid_res.pos;
        n_out_data[14]    = ip_res.first_write;
        n_out_data[18:15] = ip_res.first_pos;
        n_out_data[19]    = ip_res.second_write;
        n_out_data[23:20] = ip_res.second_pos;
        n_out_data[24]    = ip_res.overflow;
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && r_in_valid) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

endmodule

### hw/rtl/sfe_ssid_capture.sv
// ssid capture: arms on :" and stores characters until a quote or capacity
// depends on sfe_pkg
module sfe_ssid_capture #(
    parameter int SSID_CAPACITY = sfe_pkg::SSID_CAP_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,        // byte is nonzero
    input  logic               i_adv,       // byte is being consumed
    input  logic [7:0]         i_byte,
    input  logic [7:0]         i_last_byte,
    output sfe_pkg::t_ssid_res o_res
);

    localparam int CW = $clog2(SSID_CAPACITY + 1);
    localparam logic [CW-1:0] CAP = CW'(SSID_CAPACITY);

    logic          r_active, n_active;
    logic [CW-1:0] r_count, n_count;
    logic          is_quote;
    logic          wr;

    // capture step followed by the re-arm check on the updated count
    always_comb begin
        is_quote = (i_byte == sfe_pkg::CH_QUOTE);
        wr       = i_en && r_active && !is_quote && (r_count < CAP);
        n_count  = r_count + CW'(wr);
        n_active = r_active;
        if (r_active && (is_quote || n_count >= CAP)) begin
            n_active = 1'b0;
        end
        if ((n_count < CAP) && (i_last_byte == sfe_pkg::CH_COLON) && is_quote) begin
            n_active = 1'b1;
        end
    end

    // result for this byte
    always_comb begin
        o_res.write = wr;
        o_res.pos   = wr ? sfe_pkg::POS_W'(r_count) : '0;
    end

    // state update on consumed nonzero bytes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_count  <= '0;
        end else if (i_adv && i_en) begin
            r_active <= n_active;
            r_count  <= n_count;
        end
    end

endmodule

### hw/rtl/sfe_ip_capture.sv
// ip capture: arms once on P," and splits the address at the second period
// depends on sfe_pkg
module sfe_ip_capture #(
    parameter int IP_GROUP_CAPACITY = sfe_pkg::IP_GROUP_CAP_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,        // byte is nonzero
    input  logic             i_adv,       // byte is being consumed
    input  logic [7:0]       i_byte,
    input  logic [7:0]       i_last_byte,
    input  logic [7:0]       i_prev_byte,
    output sfe_pkg::t_ip_res o_res
);

    localparam int CW = $clog2(IP_GROUP_CAPACITY + 1);
    localparam logic [CW-1:0] CAP = CW'(IP_GROUP_CAPACITY);

    logic          r_active, n_active;
    logic [1:0]    r_dots, n_dots;
    logic          r_first, n_first;
    logic          r_second, n_second;
    logic [CW-1:0] r_first_cnt, n_first_cnt;
    logic [CW-1:0] r_second_cnt, n_second_cnt;
    logic          is_quote;
    logic          f_wr;
    logic          g_wr;
    logic          ovf;

    // per-byte capture and group bookkeeping
    always_comb begin
        is_quote = (i_byte == sfe_pkg::CH_QUOTE);
        n_dots   = r_dots;
        if (r_active && (r_dots != 2'd3) && (i_byte == sfe_pkg::CH_DOT)) begin
            n_dots = r_dots + 2'd1;
        end
        f_wr = 1'b0;
        g_wr = 1'b0;
        ovf  = 1'b0;
        if (i_en && r_active && r_first) begin
            if (r_first_cnt < CAP) begin
                f_wr = 1'b1;
            end else begin
                ovf = 1'b1;
            end
        end
        if (i_en && r_active && r_second && !is_quote) begin
            if (r_second_cnt < CAP) begin
                g_wr = 1'b1;
            end else begin
                ovf = 1'b1;
            end
        end
        n_first_cnt  = r_first_cnt + CW'(f_wr);
        n_second_cnt = r_second_cnt + CW'(g_wr);
        n_first      = r_first;
        n_second     = r_second;
        n_active     = r_active;
        if (r_active && (n_dots == 2'd2)) begin
            n_first  = 1'b0;
            n_second = 1'b1;
        end
        if (r_active && is_quote) begin
            n_active = 1'b0;
        end
        // arm once after reset, checked on the updated group one count
        if ((n_first_cnt == '0) && (i_prev_byte == sfe_pkg::CH_P)
            && (i_last_byte == sfe_pkg::CH_COMMA) && is_quote) begin
            n_first  = 1'b1;
            n_active = 1'b1;
        end
    end

    // result for this byte
    always_comb begin
        o_res.first_write  = f_wr;
        o_res.first_pos    = f_wr ? sfe_pkg::POS_W'(r_first_cnt) : '0;
        o_res.second_write = g_wr;
        o_res.second_pos   = g_wr ? sfe_pkg::POS_W'(r_second_cnt) : '0;
        o_res.overflow     = ovf;
    end

    // state update on consumed nonzero bytes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active     <= 1'b0;
            r_dots       <= '0;
            r_first      <= 1'b0;
            r_second     <= 1'b0;
            r_first_cnt  <= '0;
            r_second_cnt <= '0;
        end else if (i_adv && i_en) begin
            r_active     <= n_active;
            r_dots       <= n_dots;
            r_first      <= n_first;
            r_second     <= n_second;
            r_first_cnt  <= n_first_cnt;
            r_second_cnt <= n_second_cnt;
        end
    end

endmodule
